/* design/assert_macros.svh */
// Assertion macros used by the checker file.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, a, b) lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
    (a) |-> (b)) else $error("implication check failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, a, b) lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
    (a) |=> (b)) else $error("next-cycle check failed");

`endif

/* design/lzwc_pkg.sv */
// Package for the LZW compressor: payload types, code constants, cell link type, FSM states.
// Used by every module of the block; depends on nothing.
package lzwc_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int CELL_BITS     = 3;
    localparam int NUM_CELLS     = 1 << CELL_BITS;
    localparam int ROW_BITS      = MAX_CODE_BITS - CELL_BITS;
    localparam int ROWS          = 1 << ROW_BITS;
    localparam int KEY_BITS      = MAX_CODE_BITS + 8;

    localparam logic [MAX_CODE_BITS-1:0] CODE_RESET = MAX_CODE_BITS'(256);
    localparam logic [MAX_CODE_BITS-1:0] CODE_END   = MAX_CODE_BITS'(257);
    localparam logic [MAX_CODE_BITS-1:0] CODE_FIRST = MAX_CODE_BITS'(258);
    localparam logic [ROW_BITS-1:0]      FIRST_ROW  = ROW_BITS'(258 >> CELL_BITS);
    localparam logic [3:0]               WIDTH_MIN  = 4'd9;
    localparam logic [3:0]               WIDTH_MAX  = 4'(MAX_CODE_BITS);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [11:0] code;
        logic [3:0]  code_width;
        logic        run_last;
    } out_item_t;

    // Match result handed from cell to cell
    typedef struct packed {
        logic                     hit;
        logic [MAX_CODE_BITS-1:0] code;
    } link_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_EMIT
    } state_t;

endpackage

/* design/lzwc_cell.sv */
// One dictionary cell: a bank of entries whose codes share the low bits cell_idx.
// Compares its registered entry with the key and passes the match along the chain.
// Depends on lzwc_pkg.
module lzwc_cell (
    input  logic                              aclk,
    input  logic [lzwc_pkg::CELL_BITS-1:0]    cell_idx,
    input  logic [lzwc_pkg::ROW_BITS-1:0]     rd_row,
    input  logic                              wr_en,
    input  logic [lzwc_pkg::ROW_BITS-1:0]     wr_row,
    input  logic [lzwc_pkg::KEY_BITS-1:0]     wr_data,
    input  logic [lzwc_pkg::KEY_BITS-1:0]     key,
    input  logic [lzwc_pkg::ROW_BITS-1:0]     cmp_row,
    input  logic [lzwc_pkg::MAX_CODE_BITS-1:0] next_free,
    input  lzwc_pkg::link_t                   link_in,
    output lzwc_pkg::link_t                   link_out
);
    import lzwc_pkg::*;

    logic [KEY_BITS-1:0]      mem_reg [ROWS];
    logic [KEY_BITS-1:0]      rdata_reg;
    logic [MAX_CODE_BITS-1:0] my_code;
    logic                     match;

    // Bank write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_row] <= wr_data;
        end
        rdata_reg <= mem_reg[rd_row];
    end

    // Only live entries can match
    assign my_code = {cmp_row, cell_idx};
    assign match   = (rdata_reg == key) && (my_code >= CODE_FIRST) && (my_code < next_free);

    always_comb begin
        link_out = link_in;
        if (match) begin
            link_out.hit  = 1'b1;
            link_out.code = my_code;
        end
    end

endmodule

/* design/lzw_compressor.sv */
// Top level of the variable-width LZW compressor: control FSM and a chain of cells.
// Depends on lzwc_pkg and lzwc_cell.
//
//  channel   | direction | payload     | handshake
//  s_        | in        | in_item_t   | s_valid / s_ready
//  m_        | out       | out_item_t  | m_valid / m_ready
//  cfg_      | in        | max_bits    | cfg_valid / cfg_ready
//
// A byte with an empty string or an empty table goes from its transfer straight to decide.
// A byte that needs a lookup goes through a bank read, then a sweep over the rows of eight cells
// 32..(next_free-1)/8 (the sweep stops at the first hit), then the decide state.
// Results then go out one per cycle while m_ready is high.
// No input is taken while results are pending. Reset is synchronous, active low,
// and clears the control state only; no clearing pass over the dictionary.
module lzw_compressor (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lzwc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lzwc_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data
);
    import lzwc_pkg::*;

    state_t                   state_reg, state_next;
    logic [7:0]               byte_reg;
    logic                     last_reg;
    logic [MAX_CODE_BITS-1:0] prefix_reg;
    logic                     pv_reg;
    logic [MAX_CODE_BITS-1:0] nfc_reg;
    logic [3:0]               cw_reg;
    logic                     started_reg;
    logic [3:0]               maxb_reg;
    logic [ROW_BITS-1:0]      row_reg, cmp_row_reg;
    logic                     cmp_valid_reg;
    logic                     hit_reg;
    logic [MAX_CODE_BITS-1:0] hit_code_reg;
    logic [4:0]               pend_reg, pend_next;
    logic [MAX_CODE_BITS-1:0] code_a_reg, code_b_reg;
    logic [3:0]               cw0_reg, cw1_reg;

    link_t                    chain [NUM_CELLS+1];
    logic [KEY_BITS-1:0]      key;
    logic [MAX_CODE_BITS-1:0] nfc_m1;
    logic [ROW_BITS-1:0]      last_row;
    logic                     done;
    logic                     miss, grow, rst2;
    logic [3:0]               eff_max, cw_after;
    logic [MAX_CODE_BITS:0]   nfc_inc, lim;
    logic [MAX_CODE_BITS-1:0] nfc_after, p_after;
    logic [4:0]               low_bit;
    logic                     run_last;
    logic                     s_fire;

    assign key      = {prefix_reg, byte_reg};
    assign nfc_m1   = nfc_reg - MAX_CODE_BITS'(1);
    assign last_row = nfc_m1[MAX_CODE_BITS-1:CELL_BITS];
    assign done     = cmp_valid_reg && (chain[NUM_CELLS].hit || (cmp_row_reg == last_row));
    assign s_fire   = s_valid && s_ready;

    // Cell chain
    assign chain[0] = '0;
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        lzwc_cell u_cell (
            .aclk      (aclk),
            .cell_idx  (CELL_BITS'(i)),
            .rd_row    (row_reg),
            .wr_en     ((state_reg == ST_DECIDE) && miss &&
                        (nfc_reg[CELL_BITS-1:0] == CELL_BITS'(i))),
            .wr_row    (nfc_reg[MAX_CODE_BITS-1:CELL_BITS]),
            .wr_data   (key),
            .key       (key),
            .cmp_row   (cmp_row_reg),
            .next_free (nfc_reg),
            .link_in   (chain[i]),
            .link_out  (chain[i+1])
        );
    end

    // Decision on the closed lookup
    always_comb begin
        eff_max = maxb_reg;
        if (maxb_reg < WIDTH_MIN) begin
            eff_max = WIDTH_MIN;
        end else if (maxb_reg > WIDTH_MAX) begin
            eff_max = WIDTH_MAX;
        end
        miss     = pv_reg && !hit_reg;
        nfc_inc  = {1'b0, nfc_reg} + (MAX_CODE_BITS+1)'(1);
        lim      = ((MAX_CODE_BITS+1)'(1) << cw_reg) - (MAX_CODE_BITS+1)'(1);
        grow     = miss && (nfc_inc >= lim);
        rst2     = grow && (cw_reg >= eff_max);
        cw_after = rst2 ? WIDTH_MIN : (grow ? cw_reg + 4'd1 : cw_reg);
        nfc_after = rst2 ? CODE_FIRST : (miss ? nfc_inc[MAX_CODE_BITS-1:0] : nfc_reg);
        p_after  = (pv_reg && hit_reg) ? hit_code_reg : {4'd0, byte_reg};
        pend_next = {last_reg, last_reg, rst2, miss, !started_reg};
    end

    // Result selection: lowest pending slot goes first
    assign low_bit  = pend_reg & (~pend_reg + 5'd1);
    assign run_last = ((pend_reg & ~low_bit) == 5'd0);

    always_comb begin
        m_data.run_last   = run_last;
        m_data.code       = CODE_RESET;
        m_data.code_width = cw0_reg;
        case (low_bit)
            5'b00001: begin m_data.code = CODE_RESET; m_data.code_width = cw0_reg; end
            5'b00010: begin m_data.code = code_a_reg; m_data.code_width = cw0_reg; end
            5'b00100: begin m_data.code = CODE_RESET; m_data.code_width = cw0_reg; end
            5'b01000: begin m_data.code = code_b_reg; m_data.code_width = cw1_reg; end
            5'b10000: begin m_data.code = CODE_END;   m_data.code_width = cw1_reg; end
            default:  begin m_data.code = CODE_RESET; m_data.code_width = cw0_reg; end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (pv_reg && (nfc_reg != CODE_FIRST)) ? ST_SEARCH : ST_DECIDE;
                end
            end
            ST_SEARCH: begin
                if (done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = (pend_next != 5'd0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (m_ready && run_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        m_valid   = (state_reg == ST_EMIT);
        cfg_ready = 1'b1;
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prefix_reg    <= '0;
            pv_reg        <= 1'b0;
            nfc_reg       <= CODE_FIRST;
            cw_reg        <= WIDTH_MIN;
            started_reg   <= 1'b0;
            maxb_reg      <= WIDTH_MAX;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            pend_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                maxb_reg <= cfg_data;
            end
            cmp_valid_reg <= (state_reg == ST_SEARCH) && !done && (row_reg <= last_row);
            if (s_fire) begin
                hit_reg <= 1'b0;
            end else if (state_reg == ST_SEARCH && done) begin
                hit_reg <= chain[NUM_CELLS].hit;
            end
            if (state_reg == ST_DECIDE) begin
                pend_reg <= pend_next;
                if (last_reg) begin
                    prefix_reg  <= '0;
                    pv_reg      <= 1'b0;
                    started_reg <= 1'b0;
                    nfc_reg     <= CODE_FIRST;
                    cw_reg      <= WIDTH_MIN;
                end else begin
                    prefix_reg  <= p_after;
                    pv_reg      <= 1'b1;
                    started_reg <= 1'b1;
                    nfc_reg     <= nfc_after;
                    cw_reg      <= cw_after;
                end
            end else if (state_reg == ST_EMIT && m_ready) begin
                pend_reg <= pend_reg & ~low_bit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            byte_reg <= s_data.data_byte;
            last_reg <= s_data.last_byte;
            row_reg  <= FIRST_ROW;
        end else begin
            row_reg  <= row_reg + ROW_BITS'(1);
        end
        cmp_row_reg <= row_reg;
        if (state_reg == ST_SEARCH && done) begin
            hit_code_reg <= chain[NUM_CELLS].code;
        end
        if (state_reg == ST_DECIDE) begin
            code_a_reg <= prefix_reg;
            code_b_reg <= p_after;
            cw0_reg    <= cw_reg;
            cw1_reg    <= cw_after;
        end
    end

endmodule

/* design/lzwc_checker.sv */
// Port-level checks for lzw_compressor, attached by the bind below.
// Depends on lzwc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lzwc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lzwc_pkg::out_item_t m_data
);
    import lzwc_pkg::*;

    // A stalled result holds
    `ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // No new byte is taken while results are still pending
    `ASSERT_IMPL(a_no_overlap, m_valid, !s_ready)
    // Code widths stay in the legal range
    `ASSERT_IMPL(a_width, m_valid, (m_data.code_width >= WIDTH_MIN) && (m_data.code_width <= WIDTH_MAX))
    // Literals and table codes never exceed the width they are sent with
    `ASSERT_IMPL(a_fits, m_valid, (m_data.code >> m_data.code_width) == '0)

endmodule

bind lzw_compressor lzwc_checker u_lzwc_checker (.*);
